[src/page_free_list_allocator_defines.svh]
// assertion macros for the page free list allocator
`ifndef PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PFLA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define PFLA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/pfla_pkg.sv]
// shared constants and control types for the page free list allocator
`timescale 1ns / 1ps
package pfla_pkg;

  localparam int PAGE_SHIFT_DEF = 12;
  localparam int MAX_PAGES_DEF  = 4096;

  localparam int ADDR_W     = 32;
  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 48;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_RANGE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP    = 2'd2;

  localparam logic [ADDR_W-1:0] KERNEL_END_RST  = 32'h8010_0000;
  localparam logic [ADDR_W-1:0] KERNEL_BASE_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] PHYS_TOP_RST    = 32'h0E00_0000;

  typedef struct packed {
    logic                load_req;
    logic                pop;
    logic                push;
    logic                step_pg;
    logic                res_set;
    logic [STATUS_W-1:0] res_code;
    logic                res_from_ram;
    logic                load_out;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic                empty;
    logic                in_range;
    logic [STATUS_W-1:0] push_code;
    logic                out_free;
  } sts_t;

endpackage

[src/pfla_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module pfla_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/pfla_datapath.sv]
// datapath: config registers, request registers, address check, stack and result output
`timescale 1ns / 1ps
module pfla_datapath #(
  parameter int PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEF,
  parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pfla_pkg::ADDR_W-1:0]      cfg_wdata_i,
  input  logic [pfla_pkg::FUNC_W-1:0]      func_i,
  input  logic [pfla_pkg::ADDR_W-1:0]      addr_i,
  input  logic [pfla_pkg::ADDR_W-1:0]      range_end_i,
  input  pfla_pkg::cmd_t                   cmd_i,
  output pfla_pkg::sts_t                   sts_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [pfla_pkg::ADDR_W-1:0]      page_addr_o,
  output logic [pfla_pkg::STATUS_W-1:0]    status_o,
  output logic [pfla_pkg::COUNT_W-1:0]     free_count_o
);
  import pfla_pkg::*;

  localparam int TOP_W = $clog2(MAX_PAGES + 1);
  localparam int IDX_W = $clog2(MAX_PAGES);
  localparam int ENT_W = ADDR_W - PAGE_SHIFT;
  localparam logic [ADDR_W:0] PG_SIZE = (ADDR_W + 1)'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W:0] PG_MASK = PG_SIZE - (ADDR_W + 1)'(1);
  localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(MAX_PAGES);

  logic [ADDR_W-1:0] kend_q, kbase_q, ptop_q;
  logic [FUNC_W-1:0] func_q;
  logic [ADDR_W-1:0] addr_q, rend_q;
  logic [ADDR_W:0]   pg_q, pg_d;
  logic [TOP_W-1:0]  top_q, top_d, top_m1;
  logic [STATUS_W-1:0] res_code_q;
  logic                res_ram_q;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_page_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic [ADDR_W-1:0] cand;
  logic [ADDR_W-1:0] phys;
  logic              good;
  logic              full;
  logic [ADDR_W+1:0] pg_end;
  logic [ENT_W-1:0]  rd_data;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kend_q  <= KERNEL_END_RST;
      kbase_q <= KERNEL_BASE_RST;
      ptop_q  <= PHYS_TOP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KERNEL_END:  kend_q  <= cfg_wdata_i;
        CFG_KERNEL_BASE: kbase_q <= cfg_wdata_i;
        CFG_PHYS_TOP:    ptop_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request registers; page cursor starts at the start rounded up, without wrap
  always_comb begin
    pg_d = pg_q;
    if (cmd_i.load_req) begin
      pg_d = ({1'b0, addr_i} + PG_MASK) & ~PG_MASK;
    end else if (cmd_i.step_pg) begin
      pg_d = pg_q + PG_SIZE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q <= func_i;
      addr_q <= addr_i;
      rend_q <= range_end_i;
    end
    pg_q <= pg_d;
    if (cmd_i.res_set) begin
      res_code_q <= cmd_i.res_code;
      res_ram_q  <= cmd_i.res_from_ram;
    end
  end

  assign cand = (func_q == FN_FREE) ? addr_q : pg_q[ADDR_W-1:0];
  assign phys = cand - kbase_q;
  assign good = (cand[PAGE_SHIFT-1:0] == '0) && (cand >= kend_q) && (phys < ptop_q);
  assign full = (top_q >= TOP_FULL);
  assign pg_end = {1'b0, pg_q} + {1'b0, PG_SIZE};

  // stack pointer
  assign top_m1 = top_q - TOP_W'(1);
  always_comb begin
    top_d = top_q;
    if (cmd_i.pop) begin
      top_d = top_m1;
    end else if (cmd_i.push) begin
      top_d = top_q + TOP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  pfla_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_PAGES)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(top_q[IDX_W-1:0]),
    .wdata_i(cand[ADDR_W-1:PAGE_SHIFT]),
    .re_i   (cmd_i.pop),
    .raddr_i(top_m1[IDX_W-1:0]),
    .rdata_o(rd_data)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_page_q   <= res_ram_q ? {rd_data, {PAGE_SHIFT{1'b0}}} : '0;
      out_status_q <= res_code_q;
      out_count_q  <= COUNT_W'(top_q);
    end
  end

  always_comb begin
    sts_o.func      = func_q;
    sts_o.empty     = (top_q == '0);
    sts_o.in_range  = (pg_end <= {2'b00, rend_q});
    sts_o.push_code = !good ? ST_BADADDR : (full ? ST_FULL : ST_OK);
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign page_addr_o  = out_page_q;
  assign status_o     = out_status_q;
  assign free_count_o = out_count_q;

endmodule

[src/pfla_ctrl.sv]
// controller state machine sequencing alloc, free and free-range requests
`timescale 1ns / 1ps
module pfla_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pfla_pkg::sts_t sts_i,
  output pfla_pkg::cmd_t cmd_o
);
  import pfla_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.func)
          FN_ALLOC: begin
            if (sts_i.empty) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
              state_d = S_FIN;
            end else begin
              cmd_o.pop = 1'b1;
              state_d = S_READ;
            end
          end
          FN_FREE: begin
            cmd_o.push     = (sts_i.push_code == ST_OK);
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = sts_i.push_code;
            state_d = S_FIN;
          end
          FN_RANGE: begin
            // one page a cycle until the range runs out or a push fails
            if (!sts_i.in_range) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = ST_OK;
              state_d = S_FIN;
            end else if (sts_i.push_code == ST_OK) begin
              cmd_o.push    = 1'b1;
              cmd_o.step_pg = 1'b1;
            end else begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = sts_i.push_code;
              state_d = S_FIN;
            end
          end
          default: begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_code = ST_OK;
            state_d = S_FIN;
          end
        endcase
      end
      S_READ: begin
        cmd_o.res_set      = 1'b1;
        cmd_o.res_code     = ST_OK;
        cmd_o.res_from_ram = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

[src/page_free_list_allocator.sv]
// Sequence: a request is registered on accept, then executed. Free, empty alloc and
// unused func go straight to the finish state; an alloc that hands out a page first
// reads the stack ram; free range pushes one page per cycle until the range ends or
// a push fails. The next item is taken once the result is in the output register.
// Reset: stack empty, config registers to defaults, no clearing pass over the stack ram.
`timescale 1ns / 1ps
module page_free_list_allocator #(
  parameter int PAGE_SHIFT = pfla_pkg::PAGE_SHIFT_DEF,
  parameter int MAX_PAGES  = pfla_pkg::MAX_PAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pfla_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfla_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // func [1:0], addr [33:2], range_end [65:34], zero fill [71:66]
  input  logic [pfla_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // page_addr [31:0], status [33:32], free_count [46:34], zero fill [47]
  output logic [pfla_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import pfla_pkg::*;

  `include "page_free_list_allocator_defines.svh"

  cmd_t cmd;
  sts_t sts;
  logic [ADDR_W-1:0]   page_addr;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  free_count;

  pfla_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pfla_datapath #(
    .PAGE_SHIFT(PAGE_SHIFT),
    .MAX_PAGES (MAX_PAGES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (s_axis_tdata[1:0]),
    .addr_i      (s_axis_tdata[33:2]),
    .range_end_i (s_axis_tdata[65:34]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .page_addr_o (page_addr),
    .status_o    (status),
    .free_count_o(free_count)
  );

  assign m_axis_tdata = {1'b0, free_count, status, page_addr};

  `PFLA_ASSERT_IMP(a_pop_not_empty, cmd.pop, !sts.empty)
  `PFLA_ASSERT_IMP(a_push_checked, cmd.push, sts.push_code == ST_OK)
  `PFLA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PFLA_ASSERT_IMP(a_empty_no_page, m_axis_tvalid && (status == ST_EMPTY), page_addr == '0)

endmodule
